// File: hdl/rgbbp_pkg.sv
// Shared constants, register codes and the item type of the RGB-to-gray row packer.
// Used by every module of the block; depends on nothing.
package rgbbp_pkg;

	localparam int MAX_WIDTH = 4096;

	localparam int PIX_W  = 8;
	localparam int ROW_W  = 13;
	localparam int THR_W  = 8;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int CMP_W  = (COL_W + 1 > ROW_W) ? COL_W + 1 : ROW_W;
	localparam int BPOS_W = 3;

	// Register codes of the configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAY_THRESH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE = 2'd2;

	localparam logic [ROW_W-1:0] ROW_WIDTH_RST   = 13'd1;
	localparam logic [THR_W-1:0] GRAY_THRESH_RST = 8'd128;
	localparam logic             MODE_PACKED     = 1'b0;
	localparam logic             MODE_GRAY       = 1'b1;

	// Luma weights and the reciprocal of 100: floor(x*41944 >> 22) == floor(x/100) for x < 43690
	localparam int SUM_W      = 15;
	localparam int RECIP_W    = 16;
	localparam int PROD_W     = SUM_W + RECIP_W;
	localparam int LUMA_SHIFT = 22;
	localparam logic [SUM_W-1:0]   LUMA_R     = 15'd30;
	localparam logic [SUM_W-1:0]   LUMA_G     = 15'd59;
	localparam logic [SUM_W-1:0]   LUMA_B     = 15'd11;
	localparam logic [RECIP_W-1:0] LUMA_RECIP = 16'd41944;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Result queue of the back end
	localparam int ODEPTH = 2;
	localparam int OCNT_W = $clog2(ODEPTH + 1);

	localparam int PAD_W = 2;

	typedef struct packed {
		logic [PIX_W-1:0]  gray;
		logic [BPOS_W-1:0] bitpos;
		logic              row_end;
		logic              emit;
		logic              gray_mode;
	} item_t;

	typedef struct packed {
		logic [PIX_W-1:0] data;
		logic             done;
	} obeat_t;

endpackage

// File: hdl/rgbbp_front.sv
// Front end: accepts pixels, tracks the column, classifies each pixel and computes its luma.
// Depends on rgbbp_pkg; feeds rgbbp_queue and takes credits back from it.
module rgbbp_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [rgbbp_pkg::PIX_W-1:0]    red,
	input  logic [rgbbp_pkg::PIX_W-1:0]    green,
	input  logic [rgbbp_pkg::PIX_W-1:0]    blue,
	input  logic [rgbbp_pkg::ROW_W-1:0]    row_width,
	input  logic                           output_mode,
	input  logic                           q_pop,
	output logic                           q_push,
	output rgbbp_pkg::item_t               q_item
);
	import rgbbp_pkg::*;

	logic              accept;
	logic [QCNT_W-1:0] occ_q;
	logic [COL_W-1:0]  col_q;
	logic [CMP_W-1:0]  col_inc;
	logic [CMP_W-1:0]  eff_width;
	logic              row_end;
	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] prod;

	logic              valid_s1;
	logic [SUM_W-1:0]  sum_s1;
	item_t             cls_s1;
	logic              valid_s2;
	item_t             item_s2;

	// Slots are reserved at accept, so the two stages never stall
	assign full   = (occ_q == QCNT_W'(QDEPTH));
	assign accept = push && !full;

	always_comb begin
		eff_width = CMP_W'(row_width);
		if (row_width == '0) begin
			eff_width = CMP_W'(1);
		end else if (CMP_W'(row_width) > CMP_W'(MAX_WIDTH)) begin
			eff_width = CMP_W'(MAX_WIDTH);
		end
	end

	assign col_inc = CMP_W'(col_q) + CMP_W'(1);
	assign row_end = (col_inc >= eff_width);

	assign sum = SUM_W'(red) * LUMA_R + SUM_W'(green) * LUMA_G + SUM_W'(blue) * LUMA_B;
	assign prod = PROD_W'(sum_s1) * PROD_W'(LUMA_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			case ({accept, q_pop})
				2'b10:   occ_q <= occ_q + QCNT_W'(1);
				2'b01:   occ_q <= occ_q - QCNT_W'(1);
				default: occ_q <= occ_q;
			endcase
			if (accept) begin
				col_q <= row_end ? '0 : col_inc[COL_W-1:0];
			end
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1           <= sum;
			cls_s1.gray      <= '0;
			cls_s1.bitpos    <= col_q[BPOS_W-1:0];
			cls_s1.row_end   <= row_end;
			cls_s1.gray_mode <= (output_mode == MODE_GRAY);
			cls_s1.emit      <= (output_mode == MODE_GRAY) || row_end
				|| (col_q[BPOS_W-1:0] == '1);
		end
		if (valid_s1) begin
			item_s2 <= '{gray:      prod[LUMA_SHIFT +: PIX_W],
			             bitpos:    cls_s1.bitpos,
			             row_end:   cls_s1.row_end,
			             emit:      cls_s1.emit,
			             gray_mode: cls_s1.gray_mode};
		end
	end

	assign q_push = valid_s2;
	assign q_item = item_s2;

	a_push_holds_credit: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (occ_q != '0))
		else $error("credit lost after an accepted pixel");

endmodule

// File: hdl/rgbbp_queue.sv
// Short queue of classified pixels between the front and back ends.
// Depends on rgbbp_pkg for the item type and depth.
module rgbbp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  rgbbp_pkg::item_t wr_item,
	input  logic             rd,
	output logic             rd_valid,
	output rgbbp_pkg::item_t rd_item
);
	import rgbbp_pkg::*;

	item_t             mem [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wptr_q] <= wr_item;
		end
	end

endmodule

// File: hdl/rgbbp_back.sv
// Back end: thresholds and packs bits or passes gray bytes, pads rows to four-byte multiples, queues result bytes.
// Depends on rgbbp_pkg; reads items from rgbbp_queue.
module rgbbp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rgbbp_pkg::THR_W-1:0]   gray_threshold,
	input  logic                          q_valid,
	input  rgbbp_pkg::item_t              q_item,
	output logic                          q_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic [rgbbp_pkg::PIX_W-1:0]   out_byte,
	output logic                          row_done
);
	import rgbbp_pkg::*;

	logic [PIX_W-1:0]  acc_q;
	logic [PAD_W-1:0]  rbc_q;
	logic [PAD_W-1:0]  pad_left_q;
	obeat_t            obuf [ODEPTH];
	logic              owptr_q;
	logic              orptr_q;
	logic [OCNT_W-1:0] ocnt_q;

	logic              out_room;
	logic              out_wr;
	obeat_t            out_beat;
	logic              out_rd;
	logic [PIX_W-1:0]  acc_or;
	logic [PIX_W-1:0]  data;
	logic [PAD_W-1:0]  rbc_new;
	logic [PAD_W-1:0]  pad;

	assign out_room = (ocnt_q != OCNT_W'(ODEPTH));
	assign out_rd   = pop && (ocnt_q != '0);

	always_comb begin
		acc_or = acc_q;
		if (q_item.gray >= gray_threshold) begin
			acc_or = acc_q | (8'h80 >> q_item.bitpos);
		end
		data    = q_item.gray_mode ? q_item.gray : acc_or;
		rbc_new = rbc_q + PAD_W'(q_item.emit);
		pad     = PAD_W'(0) - rbc_new;

		q_pop         = 1'b0;
		out_wr        = 1'b0;
		out_beat.data = '0;
		out_beat.done = 1'b0;
		if (pad_left_q != '0) begin
			// pad the row with zero bytes, last one flagged
			out_wr        = out_room;
			out_beat.done = (pad_left_q == PAD_W'(1));
		end else if (q_valid) begin
			q_pop         = !q_item.emit || out_room;
			out_wr        = q_item.emit && out_room;
			out_beat.data = data;
			out_beat.done = q_item.row_end && (pad == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			rbc_q      <= '0;
			pad_left_q <= '0;
			owptr_q    <= 1'b0;
			orptr_q    <= 1'b0;
			ocnt_q     <= '0;
		end else begin
			if (pad_left_q != '0) begin
				if (out_room) begin
					pad_left_q <= pad_left_q - PAD_W'(1);
				end
			end else if (q_pop) begin
				acc_q      <= (q_item.emit || q_item.row_end) ? '0 : acc_or;
				rbc_q      <= q_item.row_end ? '0 : rbc_new;
				pad_left_q <= q_item.row_end ? pad : '0;
			end
			if (out_wr) begin
				owptr_q <= !owptr_q;
			end
			if (out_rd) begin
				orptr_q <= !orptr_q;
			end
			case ({out_wr, out_rd})
				2'b10:   ocnt_q <= ocnt_q + OCNT_W'(1);
				2'b01:   ocnt_q <= ocnt_q - OCNT_W'(1);
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_wr) begin
			obuf[owptr_q] <= out_beat;
		end
	end

	assign empty    = (ocnt_q == '0);
	assign out_byte = obuf[orptr_q].data;
	assign row_done = obuf[orptr_q].done;

	a_no_pop_while_padding: assert property (@(posedge clk) disable iff (!arst_n)
		(pad_left_q != '0) |-> !q_pop)
		else $error("pixel taken while row padding is pending");

	a_row_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_wr && out_beat.done) |=> (pad_left_q == '0) && (rbc_q == '0))
		else $error("row state not cleared after the final row beat");

	a_emit_written: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.emit) |-> out_wr)
		else $error("emitting pixel consumed without a result beat");

endmodule

// File: hdl/rgb_gray_binarize_row_packer.sv
// Top level of the RGB-to-gray converter with 1-bit threshold packing and row padding.
// Depends on rgbbp_pkg, rgbbp_front, rgbbp_queue and rgbbp_back.
//
// Takes one RGB pixel per clock while full is low, in row order, and delivers a stream of bytes:
// gray bytes (output_mode 1) or 1-bit pixels packed MSB first (output_mode 0), each row padded
// with zero bytes to a multiple of four and its last byte flagged by row_done. A pixel passes
// through the sum stage, the reciprocal multiply stage, the pixel queue and the result queue
// before it can be popped. Pixels are accepted at one per cycle as long as results are popped;
// the back end writes at most one byte per cycle into its two-entry result queue, so a row end
// holds the four-entry pixel queue while up to three padding bytes go out, and full rises if
// that backs up.
// Write configuration only while idle; row_width 0 acts as 1 and widths above 4096 saturate.
module rgb_gray_binarize_row_packer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [rgbbp_pkg::PIX_W-1:0]       red,
	input  logic [rgbbp_pkg::PIX_W-1:0]       green,
	input  logic [rgbbp_pkg::PIX_W-1:0]       blue,
	output logic                              empty,
	input  logic                              pop,
	output logic [rgbbp_pkg::PIX_W-1:0]       out_byte,
	output logic                              row_done,
	input  logic                              cfg_write,
	input  logic [rgbbp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rgbbp_pkg::ROW_W-1:0]       cfg_data
);
	import rgbbp_pkg::*;

	logic [ROW_W-1:0] row_width_q;
	logic [THR_W-1:0] gray_threshold_q;
	logic             output_mode_q;

	logic  q_push;
	logic  q_pop;
	logic  q_valid;
	item_t q_wr_item;
	item_t q_rd_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q      <= ROW_WIDTH_RST;
			gray_threshold_q <= GRAY_THRESH_RST;
			output_mode_q    <= MODE_PACKED;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROW_WIDTH:   row_width_q      <= cfg_data;
				REG_GRAY_THRESH: gray_threshold_q <= cfg_data[THR_W-1:0];
				REG_OUTPUT_MODE: output_mode_q    <= cfg_data[0];
				default:         row_width_q      <= row_width_q;
			endcase
		end
	end

	rgbbp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.row_width   (row_width_q),
		.output_mode (output_mode_q),
		.q_pop       (q_pop),
		.q_push      (q_push),
		.q_item      (q_wr_item)
	);

	rgbbp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_push),
		.wr_item  (q_wr_item),
		.rd       (q_pop),
		.rd_valid (q_valid),
		.rd_item  (q_rd_item)
	);

	rgbbp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.gray_threshold (gray_threshold_q),
		.q_valid        (q_valid),
		.q_item         (q_rd_item),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.row_done       (row_done)
	);

endmodule
